// File: sv/mluf_pkg.sv
// ----------------------------------------------------------------------------
// mluf_pkg: shared types and constants of the mutex lock unit
// Word formats, request and status codes, and the wait queue control bundles.
// ----------------------------------------------------------------------------
package mluf_pkg;

  localparam int ThreadCount = 16;
  localparam int QueueDepth  = 16;
  localparam int CountBits   = 8;

  localparam int IdW = 4;

  localparam logic [1:0] FUNC_TRY_LOCK = 2'd0;
  localparam logic [1:0] FUNC_LOCK     = 2'd1;
  localparam logic [1:0] FUNC_UNLOCK   = 2'd2;

  localparam logic [2:0] ST_SUCCESS = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam int          RegCount       = 1;
  localparam int          PaddrW         = 3;
  localparam logic [PaddrW-1:0] REG_RECURSIVE_MODE = 3'd0;

  typedef struct packed {
    logic [1:0]     func;
    logic [IdW-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]     status;
    logic           grant_valid;
    logic [IdW-1:0] granted_thread;
    logic           owner_valid;
    logic [IdW-1:0] owner_id;
  } rsp_t;

  // control from the lock logic to the wait queue
  typedef struct packed {
    logic           push;
    logic           pop;
    logic [IdW-1:0] push_id;
  } queue_ctrl_t;

  // status from the wait queue back to the lock logic
  typedef struct packed {
    logic           empty;
    logic           full;
    logic [IdW-1:0] head_id;
  } queue_stat_t;

endpackage

// File: sv/mutex_lock_unit_fifo_waiters.sv
// ----------------------------------------------------------------------------
// mutex_lock_unit_fifo_waiters: recursive mutex with a FIFO wait queue
// Serves try_lock, lock and unlock requests and reports owner and grants.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid_i / req_ready_o / req_i) carries one word per
//   request: func (try_lock, lock, unlock) and thread_id. Response channel
//   (rsp_valid_o / rsp_ready_i / rsp_o) returns one word per request: status,
//   grant to the head waiter on a final unlock, and the owner after the step.
//   The response is registered at the edge that accepts the request.
//   Throughput is one request per cycle while the receiver keeps up; the
//   single response register sets it, and a new request is taken in the
//   same cycle the waiting response is taken.
//   When the receiver stalls, the response register holds its word and
//   req_ready_o drops until the word is taken.
//   The wait queue is a row of cells that shift toward the head on each
//   handover; a push loads the first free cell.
//   Reset: mutex free, owner and nest count zero, queue empty, recursive mode
//   off. No clearing pass is needed; requests are taken right after reset.
//   Configuration: APB register 0 (byte address 0) holds recursive_mode in
//   bit 0. Write it only while no request is in flight.
// ----------------------------------------------------------------------------
module mutex_lock_unit_fifo_waiters (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  mluf_pkg::req_t               req_i,

  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output mluf_pkg::rsp_t               rsp_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mluf_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CB = mluf_pkg::CountBits;

  // mode register
  logic recursive_q;

  // lock state
  logic                      held_q, held_d;
  logic [mluf_pkg::IdW-1:0]  owner_q, owner_d;
  logic [CB-1:0]             nest_q, nest_d;

  // response register
  logic                      rsp_valid_q;
  mluf_pkg::rsp_t            rsp_q, rsp_d;

  mluf_pkg::queue_ctrl_t     q_ctrl;
  mluf_pkg::queue_stat_t     q_stat;

  logic                      accept;
  logic [CB-1:0]             nest_dec;

  // --- configuration port ---------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == mluf_pkg::REG_RECURSIVE_MODE) ? {31'b0, recursive_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recursive_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == mluf_pkg::REG_RECURSIVE_MODE) begin
      recursive_q <= pwdata[0];
    end
  end

  // --- handshake --------------------------------------------------------------
  // take a new request when the response slot is empty or drains this cycle
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // --- request decode -------------------------------------------------------
  assign nest_dec = (nest_q != '0) ? nest_q - CB'(1) : nest_q;

  always_comb begin
    held_d          = held_q;
    owner_d         = owner_q;
    nest_d          = nest_q;
    q_ctrl.push     = 1'b0;
    q_ctrl.pop      = 1'b0;
    q_ctrl.push_id  = req_i.thread_id;
    rsp_d.status         = mluf_pkg::ST_SUCCESS;
    rsp_d.grant_valid    = 1'b0;
    rsp_d.granted_thread = '0;

    if (int'(req_i.thread_id) >= mluf_pkg::ThreadCount) begin
      rsp_d.status = mluf_pkg::ST_ERROR;
    end else begin
      unique case (req_i.func)
        mluf_pkg::FUNC_TRY_LOCK: begin
          if (held_q) begin
            rsp_d.status = mluf_pkg::ST_BUSY;
          end else begin
            held_d  = 1'b1;
            owner_d = req_i.thread_id;
            nest_d  = CB'(1);
          end
        end
        mluf_pkg::FUNC_LOCK: begin
          priority if (!held_q) begin
            held_d  = 1'b1;
            owner_d = req_i.thread_id;
            nest_d  = CB'(1);
          end else if (owner_q == req_i.thread_id) begin
            // in recursive mode, nest on relock; saturate at the top of the counter
            if (recursive_q && nest_q != '1) begin
              nest_d = nest_q + CB'(1);
            end
          end else if (q_stat.full) begin
            rsp_d.status = mluf_pkg::ST_FULL;
          end else begin
            q_ctrl.push  = accept;
            rsp_d.status = mluf_pkg::ST_BLOCKED;
          end
        end
        mluf_pkg::FUNC_UNLOCK: begin
          if (!held_q || owner_q != req_i.thread_id) begin
            rsp_d.status = mluf_pkg::ST_ERROR;
          end else begin
            priority if (recursive_q && nest_dec != '0) begin
              nest_d = nest_dec;
            end else if (q_stat.empty) begin
              held_d  = 1'b0;
              owner_d = '0;
              nest_d  = '0;
            end else begin
              // hand ownership to the head waiter
              q_ctrl.pop           = accept;
              owner_d              = q_stat.head_id;
              nest_d               = CB'(1);
              rsp_d.grant_valid    = 1'b1;
              rsp_d.granted_thread = q_stat.head_id;
            end
          end
        end
        default: begin
          // unused code: no change, success
        end
      endcase
    end

    rsp_d.owner_valid = held_d;
    rsp_d.owner_id    = held_d ? owner_d : '0;
  end

  // --- wait queue ---------------------------------------------------------
  mluf_wait_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat)
  );

  // --- state and response registers ---------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      owner_q     <= '0;
      nest_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        held_q  <= held_d;
        owner_q <= owner_d;
        nest_q  <= nest_d;
      end
      // hold the word until taken; load on every accept
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: sv/mluf_wait_cell.sv
// ----------------------------------------------------------------------------
// mluf_wait_cell: one slot of the wait queue
// Holds one waiting thread id; shifts toward the head on pop, loads on push.
// ----------------------------------------------------------------------------
module mluf_wait_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mluf_pkg::queue_ctrl_t         ctrl_i,
  input  logic                          prev_valid_i,
  input  logic                          next_valid_i,
  input  logic [mluf_pkg::IdW-1:0]      next_id_i,
  output logic                          valid_o,
  output logic [mluf_pkg::IdW-1:0]      id_o
);

  logic                     valid_q, valid_d;
  logic [mluf_pkg::IdW-1:0] id_q, id_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      id_d    = next_id_i;
    end else if (ctrl_i.push && !valid_q && prev_valid_i) begin
      // first free slot takes the new waiter
      valid_d = 1'b1;
      id_d    = ctrl_i.push_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;

endmodule

// File: sv/mluf_wait_queue.sv
// ----------------------------------------------------------------------------
// mluf_wait_queue: first-in first-out queue of waiting threads
// A row of cells; the head sits in cell 0 and the row shifts down on pop.
// ----------------------------------------------------------------------------
module mluf_wait_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mluf_pkg::queue_ctrl_t ctrl_i,
  output mluf_pkg::queue_stat_t stat_o
);

  localparam int Depth = mluf_pkg::QueueDepth;

  logic [Depth-1:0]             cell_valid;
  logic [mluf_pkg::IdW-1:0]     cell_id [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                     prev_valid;
    logic                     next_valid;
    logic [mluf_pkg::IdW-1:0] next_id;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_id    = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_id    = cell_id[i+1];
    end

    mluf_wait_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_id_i    (next_id),
      .valid_o      (cell_valid[i]),
      .id_o         (cell_id[i])
    );
  end

  assign stat_o.empty   = !cell_valid[0];
  assign stat_o.full    = cell_valid[Depth-1];
  assign stat_o.head_id = cell_id[0];

endmodule

// File: sv/mluf_checker.sv
// ----------------------------------------------------------------------------
// mluf_port_checks: port-level checks of the mutex lock unit
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module mluf_port_checks (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_o,
  input mluf_pkg::req_t  req_i,
  input logic            rsp_valid_o,
  input logic            rsp_ready_i,
  input mluf_pkg::rsp_t  rsp_o
);

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response word changed while stalled");

  // every accepted request yields a response next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> rsp_valid_o)
    else $error("accepted request produced no response");

  // a grant makes the granted thread the owner
  a_grant_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.grant_valid |->
      rsp_o.owner_valid && rsp_o.owner_id == rsp_o.granted_thread)
    else $error("granted thread is not the owner");

  // a free mutex reports no owner and no grant
  a_free_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.owner_valid |->
      rsp_o.owner_id == '0 && !rsp_o.grant_valid)
    else $error("free mutex reports owner or grant");

  // busy only when held
  a_busy_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == mluf_pkg::ST_BUSY |-> rsp_o.owner_valid)
    else $error("busy reported on a free mutex");

endmodule

bind mutex_lock_unit_fifo_waiters mluf_port_checks u_port_checks (.*);

// File: verif/mluf_checker.sv
// ----------------------------------------------------------------------------
// mluf_checker: response checker for the mutex lock unit
// Watches the request, response and register channels, keeps its own model
// of owner, nest count and wait line, and compares every response word.
// ----------------------------------------------------------------------------
module mluf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  mluf_pkg::req_t              req_i,

  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  mluf_pkg::rsp_t              rsp_i,

  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [mluf_pkg::PaddrW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,

  output int                          mismatch_count_o,
  output int                          pending_o,
  output logic                        lock_held_o,
  output logic [mluf_pkg::IdW-1:0]    lock_owner_o
);
  import mluf_pkg::*;

  logic                 recursive_mode;
  logic                 held;
  logic [IdW-1:0]       owner;
  logic [CountBits-1:0] nest;
  logic [IdW-1:0]       wait_line [QueueDepth];
  int                   wait_head;
  int                   wait_tail;
  int                   wait_count;
  rsp_t                 expected_rsp_q [$];
  int                   mismatches;

  // Apply one request to the lock model and return the word it answers.
  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_SUCCESS;
    if (int'(r.thread_id) >= ThreadCount) begin
      o.status = ST_ERROR;
    end else begin
      case (r.func)
        FUNC_TRY_LOCK: begin
          if (held) begin
            o.status = ST_BUSY;
          end else begin
            held  = 1'b1;
            owner = r.thread_id;
            nest  = CountBits'(1);
          end
        end
        FUNC_LOCK: begin
          if (!held) begin
            held  = 1'b1;
            owner = r.thread_id;
            nest  = CountBits'(1);
          end else if (owner == r.thread_id) begin
            if (recursive_mode && nest != {CountBits{1'b1}}) nest = nest + 1'b1;
          end else if (wait_count >= QueueDepth) begin
            o.status = ST_FULL;
          end else begin
            wait_line[wait_tail] = r.thread_id;
            wait_tail = (wait_tail + 1) % QueueDepth;
            wait_count++;
            o.status = ST_BLOCKED;
          end
        end
        FUNC_UNLOCK: begin
          if (!held || owner != r.thread_id) begin
            o.status = ST_ERROR;
          end else begin
            if (nest != 0) nest = nest - 1'b1;
            if (recursive_mode && nest != 0) begin
              // still nested: keep the owner
            end else if (wait_count == 0) begin
              held  = 1'b0;
              owner = '0;
              nest  = '0;
            end else begin
              owner = wait_line[wait_head];
              wait_head = (wait_head + 1) % QueueDepth;
              wait_count--;
              nest = CountBits'(1);
              o.grant_valid    = 1'b1;
              o.granted_thread = owner;
            end
          end
        end
        default: ;
      endcase
    end
    o.owner_valid = held;
    o.owner_id    = held ? owner : '0;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_w;
    if (!rst_ni) begin
      recursive_mode = 1'b0;
      held       = 1'b0;
      owner      = '0;
      nest       = '0;
      wait_head  = 0;
      wait_tail  = 0;
      wait_count = 0;
      mismatches = 0;
      for (int i = 0; i < QueueDepth; i++) wait_line[i] = '0;
      expected_rsp_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == REG_RECURSIVE_MODE) begin
        recursive_mode = pwdata_i[0];
      end
      // retire the response first: it belongs to an earlier request
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word %p", rsp_i);
        end else begin
          exp_w = expected_rsp_q.pop_front();
          if (rsp_i.status !== exp_w.status || rsp_i.grant_valid !== exp_w.grant_valid ||
              rsp_i.granted_thread !== exp_w.granted_thread ||
              rsp_i.owner_valid !== exp_w.owner_valid || rsp_i.owner_id !== exp_w.owner_id) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("response mismatch: expected st=%0d grant=%0b/%0d owner=%0b/%0d, got st=%0d grant=%0b/%0d owner=%0b/%0d",
                       exp_w.status, exp_w.grant_valid, exp_w.granted_thread,
                       exp_w.owner_valid, exp_w.owner_id,
                       rsp_i.status, rsp_i.grant_valid, rsp_i.granted_thread,
                       rsp_i.owner_valid, rsp_i.owner_id);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsp_q.push_back(serve_request(req_i));
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_rsp_q.size();
    lock_held_o      <= held;
    lock_owner_o     <= owner;
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the mutex lock unit
// Drives directed and random lock, try_lock and unlock words, flips recursive
// mode between phases, and lets the checker judge every response word.
// ----------------------------------------------------------------------------
module testbench;
  import mluf_pkg::*;

  // func code 3 is not a request; the block must answer it and change nothing
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam int ItemTarget = 950;
  localparam int TailStart  = 820;   // no idling from here on
  localparam int HoldCycles = 300;   // long receiver hold-off

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;

  logic              req_valid;
  logic              req_ready;
  req_t              req_word;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp_word;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int                mismatch_count;
  int                pending;
  logic              lock_held;
  logic [IdW-1:0]    lock_owner;

  // shared between the request driver and the response sink
  logic              idle_on = 1'b1;
  int                hold_asked = 0;
  int                hold_given = 0;

  int                sent_count = 0;
  logic              cur_mode = 1'b0;

  always #1 clk = ~clk;

  mutex_lock_unit_fifo_waiters i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_word),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mluf_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_valid_i      (req_valid),
    .req_ready_i      (req_ready),
    .req_i            (req_word),
    .rsp_valid_i      (rsp_valid),
    .rsp_ready_i      (rsp_ready),
    .rsp_i            (rsp_word),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .lock_held_o      (lock_held),
    .lock_owner_o     (lock_owner)
  );

  // Offer one request word, maybe after an idle burst, and hold it until taken.
  // Valid stays high on return so a following word goes out back to back.
  task automatic send_req(logic [1:0] f, logic [IdW-1:0] t);
    req_t w;
    w.func      = f;
    w.thread_id = t;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (!req_ready);
    if (f != FUNC_NONE) sent_count++;
  endtask

  task automatic send_noise();
    send_req(2'($urandom_range(0, 3)), IdW'($urandom_range(0, ThreadCount - 1)));
  endtask

  // Drop valid and wait until every expected response word has come back.
  // The checker publishes its counts through registers, so look only from the
  // edge after the last accept onward.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // Write recursive_mode: setup cycle, then access cycle until pready.
  task automatic write_mode(logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RECURSIVE_MODE;
    pwdata  <= {31'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = m;
  endtask

  // Bring the mutex back to free with an empty wait line. Turn recursion off
  // first so a nested owner releases in one unlock; each unlock waits for its
  // answer so the published owner is current.
  task automatic settle();
    drain();
    if (lock_held) begin
      if (cur_mode) write_mode(1'b0);
      while (lock_held) begin
        send_req(FUNC_UNLOCK, lock_owner);
        drain();
      end
    end
  endtask

  // Well-formed round: take the mutex, optionally nest, queue waiters (past
  // the line depth now and then), then walk ownership down the line.
  // Stray words are mixed in; settle cleans up whatever they break.
  task automatic run_handover();
    logic [IdW-1:0] own;
    logic [IdW-1:0] w;
    logic [IdW-1:0] line_q [$];
    int             depth;
    int             waiters;
    own   = IdW'($urandom_range(0, ThreadCount - 1));
    depth = $urandom_range(0, 3);
    send_req($urandom_range(0, 1) ? FUNC_LOCK : FUNC_TRY_LOCK, own);
    repeat (depth) send_req(FUNC_LOCK, own);
    waiters = $urandom_range(0, QueueDepth + 4);
    for (int i = 0; i < waiters; i++) begin
      do w = IdW'($urandom_range(0, ThreadCount - 1)); while (w == own);
      send_req(FUNC_LOCK, w);
      if (line_q.size() < QueueDepth) line_q.push_back(w);
      if ($urandom_range(0, 7) == 0) send_noise();
    end
    if (cur_mode) repeat (depth) send_req(FUNC_UNLOCK, own);
    send_req(FUNC_UNLOCK, own);
    foreach (line_q[i]) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_req(FUNC_UNLOCK, line_q[i]);
    end
  endtask

  // Response sink: long hold-off on request, random stall bursts while idling is on.
  initial begin
    rsp_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_given != hold_asked) begin
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_given++;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int round;
    req_valid <= 1'b0;
    req_word  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, recursion off (reset value): error on a free mutex, the
    // unused func code, busy try_lock, plain relock by the owner, repeated
    // waiter, unlock by a stranger, and handover in line order.
    send_req(FUNC_UNLOCK,   4'd0);
    send_req(FUNC_NONE,     4'd15);
    send_req(FUNC_TRY_LOCK, 4'd0);
    send_req(FUNC_TRY_LOCK, 4'd15);
    send_req(FUNC_LOCK,     4'd0);
    send_req(FUNC_LOCK,     4'd15);
    send_req(FUNC_LOCK,     4'd15);
    send_req(FUNC_LOCK,     4'd7);
    send_req(FUNC_UNLOCK,   4'd15);
    send_req(FUNC_UNLOCK,   4'd0);
    send_req(FUNC_UNLOCK,   4'd15);
    send_req(FUNC_UNLOCK,   4'd15);
    send_req(FUNC_NONE,     4'd0);
    send_req(FUNC_UNLOCK,   4'd7);
    send_req(FUNC_LOCK,     4'd10);
    send_req(FUNC_UNLOCK,   4'd10);
    drain();

    // Directed, recursion on: nest, queue, unwind, hand over, release.
    write_mode(1'b1);
    send_req(FUNC_LOCK,   4'd15);
    send_req(FUNC_LOCK,   4'd15);
    send_req(FUNC_LOCK,   4'd3);
    send_req(FUNC_UNLOCK, 4'd15);
    send_req(FUNC_UNLOCK, 4'd15);
    send_req(FUNC_UNLOCK, 4'd3);
    drain();

    // Nest past the count limit so it saturates, unwind a little, then let
    // settle turn recursion off while still nested.
    repeat ((1 << CountBits) + 2) send_req(FUNC_LOCK, 4'd9);
    send_req(FUNC_TRY_LOCK, 4'd2);
    send_req(FUNC_UNLOCK, 4'd9);
    send_req(FUNC_UNLOCK, 4'd9);
    settle();

    round = 0;
    while (sent_count < ItemTarget) begin
      idle_on = (sent_count < TailStart) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
      // hold the sink off while words keep coming so the block backs up
      if (round == 2 || round == 25) hold_asked++;
      if ($urandom_range(0, 9) < 7) begin
        run_handover();
      end else begin
        repeat ($urandom_range(5, 25)) send_noise();
      end
      settle();
      round++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS mutex_lock_unit_fifo_waiters");
    end else begin
      $display("FAIL mutex_lock_unit_fifo_waiters");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1000000;
    $display("FAIL mutex_lock_unit_fifo_waiters");
    $finish;
  end

endmodule

// File: files.f
sv/mluf_pkg.sv
sv/mluf_wait_cell.sv
sv/mluf_wait_queue.sv
sv/mutex_lock_unit_fifo_waiters.sv
sv/mluf_checker.sv
verif/mluf_checker.sv
verif/testbench.sv
